>>> hdl/sdsh_pkg.sv
// Package for the SD card SPI-mode host sequencer.
// Phase codes, command and status codes, state and result types, frame byte helpers.
// No dependencies.
package sdsh_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int DUMMY_BYTES = 10;

  localparam int PHASE_W = 5;
  localparam int COUNT_W = 10;
  localparam int WAIT_W  = 16;

  localparam logic [PHASE_W-1:0] PH_IDLE     = 5'd0;
  localparam logic [PHASE_W-1:0] PH_DUMMY    = 5'd1;
  localparam logic [PHASE_W-1:0] PH_C0_SEND  = 5'd2;
  localparam logic [PHASE_W-1:0] PH_C0_RESP  = 5'd3;
  localparam logic [PHASE_W-1:0] PH_C8_SEND  = 5'd4;
  localparam logic [PHASE_W-1:0] PH_C8_RESP  = 5'd5;
  localparam logic [PHASE_W-1:0] PH_C55_SEND = 5'd6;
  localparam logic [PHASE_W-1:0] PH_C55_RESP = 5'd7;
  localparam logic [PHASE_W-1:0] PH_A41_SEND = 5'd8;
  localparam logic [PHASE_W-1:0] PH_A41_RESP = 5'd9;
  localparam logic [PHASE_W-1:0] PH_RW_SEND  = 5'd10;
  localparam logic [PHASE_W-1:0] PH_RW_RESP  = 5'd11;
  localparam logic [PHASE_W-1:0] PH_TOKEN    = 5'd12;
  localparam logic [PHASE_W-1:0] PH_RDATA    = 5'd13;
  localparam logic [PHASE_W-1:0] PH_RCRC     = 5'd14;
  localparam logic [PHASE_W-1:0] PH_WTOKEN   = 5'd15;
  localparam logic [PHASE_W-1:0] PH_WDATA    = 5'd16;
  localparam logic [PHASE_W-1:0] PH_WCRC     = 5'd17;
  localparam logic [PHASE_W-1:0] PH_DRESP    = 5'd18;
  localparam logic [PHASE_W-1:0] PH_BUSY     = 5'd19;
  localparam logic [PHASE_W-1:0] PH_FINAL_OK = 5'd20;
  localparam logic [PHASE_W-1:0] PH_FINAL_TO = 5'd21;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_XFER  = 2'd3;

  localparam logic [1:0] CFG_RESPONSE_TRIES = 2'd0;
  localparam logic [1:0] CFG_INIT_RETRIES   = 2'd1;
  localparam logic [1:0] CFG_TOKEN_TRIES    = 2'd2;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_CMD_REJECTED  = 3'd1;
  localparam logic [2:0] ST_INIT_TIMEOUT  = 3'd2;
  localparam logic [2:0] ST_TOKEN_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_DATA_REJECTED = 3'd4;

  localparam logic [7:0] OP_CMD0   = 8'h40;
  localparam logic [7:0] OP_CMD8   = 8'h48;
  localparam logic [7:0] OP_CMD17  = 8'h51;
  localparam logic [7:0] OP_CMD24  = 8'h58;
  localparam logic [7:0] OP_CMD55  = 8'h77;
  localparam logic [7:0] OP_ACMD41 = 8'h69;
  localparam logic [7:0] CRC_CMD0  = 8'h95;
  localparam logic [7:0] CRC_CMD8  = 8'h87;
  localparam logic [7:0] CRC_CMD55 = 8'h65;
  localparam logic [7:0] CRC_A41   = 8'h77;
  localparam logic [31:0] ARG_CMD8 = 32'h0000_01AA;
  localparam logic [31:0] ARG_A41  = 32'h4000_0000;
  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] DRESP_MASK  = 8'h1F;
  localparam logic [7:0] DRESP_OK    = 8'h05;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [1:0]         operation;
    logic [31:0]        byte_address;
    logic [COUNT_W-1:0] byte_count;
    logic [WAIT_W-1:0]  wait_count;
    logic [WAIT_W-1:0]  retry_count;
  } seq_state_t;

  typedef struct packed {
    logic [7:0]  response_tries;
    logic [15:0] init_retries;
    logic [15:0] token_tries;
  } seq_cfg_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_active;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic [2:0] status;
  } seq_res_t;

  function automatic seq_res_t mk_res(logic txv, logic [7:0] tx, logic cs, logic dv,
                                      logic [7:0] db, logic done, logic [2:0] st);
    seq_res_t r;
    r.tx_valid   = txv;
    r.tx_byte    = tx;
    r.cs_active  = cs;
    r.data_valid = dv;
    r.data_byte  = db;
    r.done_res   = done;
    r.status     = st;
    return r;
  endfunction

  function automatic logic [7:0] frame_byte(logic [PHASE_W-1:0] ph, logic [1:0] op_sel,
                                            logic [31:0] addr, logic [COUNT_W-1:0] idx);
    logic [7:0]  op;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [7:0]  b;
    case (ph)
      PH_C0_SEND: begin
        op = OP_CMD0; arg = '0; crc = CRC_CMD0;
      end
      PH_C8_SEND: begin
        op = OP_CMD8; arg = ARG_CMD8; crc = CRC_CMD8;
      end
      PH_C55_SEND: begin
        op = OP_CMD55; arg = '0; crc = CRC_CMD55;
      end
      PH_A41_SEND: begin
        op = OP_ACMD41; arg = ARG_A41; crc = CRC_A41;
      end
      default: begin
        op = (op_sel == CMD_READ) ? OP_CMD17 : OP_CMD24;
        arg = addr;
        crc = IDLE_BYTE;
      end
    endcase
    case (idx)
      10'd0:   b = op;
      10'd1:   b = arg[31:24];
      10'd2:   b = arg[23:16];
      10'd3:   b = arg[15:8];
      10'd4:   b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/sd_card_spi_host_sequencer.sv
// SD card SPI-mode host sequencer: top level with input, state and result registers.
// Depends on sdsh_pkg and sdsh_step.
//
// Each item is a start request or the report of one finished SPI byte exchange, and
// gives exactly one result: the next byte to send, the chip-select level, any read data
// byte and the completion status. One item is taken every clock cycle unless the input is stalled;
// an item is held in the input register while the phase decode runs, and its result is loaded into
// the result register when that register is empty or its result is not stalled. Result stalls back
// up into the input side only when both registers are full.
module sd_card_spi_host_sequencer import sdsh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] sector_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  write_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        cs_active_o,
  output logic        data_valid_o,
  output logic [7:0]  data_byte_o,
  output logic        done_res_o,
  output logic [2:0]  status_o
);

  seq_cfg_t   cfg_q;
  seq_state_t st_q;
  seq_state_t st_d;
  seq_res_t   res_d;
  seq_res_t   res_q;
  logic       in_valid_q;
  logic       out_valid_q;
  logic [1:0] command_q;
  logic [31:0] sector_q;
  logic [7:0] rx_byte_q;
  logic [7:0] write_byte_q;
  logic       out_free;
  logic       advance;
  logic       in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.response_tries <= 8'd10;
      cfg_q.init_retries   <= 16'd1000;
      cfg_q.token_tries    <= 16'd10000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RESPONSE_TRIES: cfg_q.response_tries <= cfg_wdata_i[7:0];
        CFG_INIT_RETRIES:   cfg_q.init_retries   <= cfg_wdata_i;
        CFG_TOKEN_TRIES:    cfg_q.token_tries    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      command_q    <= command_i;
      sector_q     <= sector_i;
      rx_byte_q    <= rx_byte_i;
      write_byte_q <= write_byte_i;
    end
  end

  sdsh_step u_step (
    .st_i         (st_q),
    .cfg_i        (cfg_q),
    .command_i    (command_q),
    .sector_i     (sector_q),
    .rx_byte_i    (rx_byte_q),
    .write_byte_i (write_byte_q),
    .st_o         (st_d),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_valid_o   = res_q.tx_valid;
  assign tx_byte_o    = res_q.tx_byte;
  assign cs_active_o  = res_q.cs_active;
  assign data_valid_o = res_q.data_valid;
  assign data_byte_o  = res_q.data_byte;
  assign done_res_o   = res_q.done_res;
  assign status_o     = res_q.status;

  a_done_no_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done_res |-> !res_q.tx_valid)
    else $error("done result also requests an exchange");

  a_data_polls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.data_valid |-> res_q.cs_active && res_q.tx_byte == IDLE_BYTE)
    else $error("read data byte without selected poll");

  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.done_res |-> res_q.status == ST_OK)
    else $error("status set without completion");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("decoded item lost");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room ahead");

endmodule

>>> hdl/sdsh_step.sv
// Next-phase and result decode for one item of the SD SPI host sequencer.
// Pure combinational; depends on sdsh_pkg.
module sdsh_step import sdsh_pkg::*; (
  input  seq_state_t  st_i,
  input  seq_cfg_t    cfg_i,
  input  logic [1:0]  command_i,
  input  logic [31:0] sector_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  write_byte_i,
  output seq_state_t  st_o,
  output seq_res_t    res_o
);

  logic [COUNT_W-1:0] bc_inc;
  logic [WAIT_W-1:0]  wc_inc;
  logic [WAIT_W-1:0]  retry_dec;
  logic [7:0]         resp_lim;
  logic [15:0]        init_lim;
  logic [15:0]        token_lim;
  logic [31:0]        new_addr;

  assign bc_inc    = st_i.byte_count + 1'b1;
  assign wc_inc    = st_i.wait_count + 1'b1;
  assign retry_dec = st_i.retry_count - 1'b1;
  assign resp_lim  = (cfg_i.response_tries == '0) ? 8'd1 : cfg_i.response_tries;
  assign init_lim  = (cfg_i.init_retries == '0) ? 16'd1 : cfg_i.init_retries;
  assign token_lim = (cfg_i.token_tries == '0) ? 16'd1 : cfg_i.token_tries;
  assign new_addr  = {sector_i[22:0], 9'd0};

  always_comb begin
    st_o  = st_i;
    res_o = mk_res(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
    if (command_i == CMD_INIT) begin
      st_o.operation  = CMD_INIT;
      st_o.phase      = PH_DUMMY;
      st_o.byte_count = '0;
      res_o = mk_res(1'b1, IDLE_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
    end else if (command_i == CMD_READ || command_i == CMD_WRITE) begin
      st_o.operation    = command_i;
      st_o.byte_address = new_addr;
      st_o.phase        = PH_RW_SEND;
      st_o.byte_count   = '0;
      res_o = mk_res(1'b1, frame_byte(PH_RW_SEND, command_i, new_addr, '0), 1'b1,
                     1'b0, 8'h00, 1'b0, ST_OK);
    end else begin
      case (st_i.phase)
        PH_DUMMY: begin
          st_o.byte_count = bc_inc;
          if (bc_inc < COUNT_W'(DUMMY_BYTES)) begin
            res_o = mk_res(1'b1, IDLE_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
          end else begin
            st_o.phase      = PH_C0_SEND;
            st_o.byte_count = '0;
            res_o = mk_res(1'b1, OP_CMD0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
          end
        end
        PH_C0_SEND, PH_C8_SEND, PH_C55_SEND, PH_A41_SEND, PH_RW_SEND: begin
          st_o.byte_count = bc_inc;
          if (bc_inc < COUNT_W'(6)) begin
            res_o = mk_res(1'b1, frame_byte(st_i.phase, st_i.operation, st_i.byte_address,
                                            bc_inc), 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
          end else begin
            st_o.phase      = st_i.phase + 1'b1;
            st_o.wait_count = '0;
            st_o.byte_count = '0;
            res_o = mk_res(1'b1, IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
          end
        end
        PH_C8_RESP: begin
          st_o.byte_count = bc_inc;
          if ((bc_inc == COUNT_W'(1) && !rx_byte_i[7]) || bc_inc >= COUNT_W'(5)) begin
            st_o.retry_count = init_lim;
            st_o.phase       = PH_C55_SEND;
            st_o.byte_count  = '0;
            res_o = mk_res(1'b1, OP_CMD55, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
          end else begin
            res_o = mk_res(1'b1, IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
          end
        end
        PH_C0_RESP, PH_C55_RESP, PH_A41_RESP, PH_RW_RESP: begin
          st_o.wait_count = wc_inc;
          if (rx_byte_i == IDLE_BYTE && wc_inc < {8'd0, resp_lim}) begin
            res_o = mk_res(1'b1, IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
          end else begin
            case (st_i.phase)
              PH_C0_RESP: begin
                if (rx_byte_i == 8'h01) begin
                  st_o.phase      = PH_C8_SEND;
                  st_o.byte_count = '0;
                  res_o = mk_res(1'b1, OP_CMD8, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                end else begin
                  st_o.phase = PH_IDLE;
                  res_o = mk_res(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, ST_CMD_REJECTED);
                end
              end
              PH_C55_RESP: begin
                st_o.phase      = PH_A41_SEND;
                st_o.byte_count = '0;
                res_o = mk_res(1'b1, OP_ACMD41, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
              end
              PH_A41_RESP: begin
                if (rx_byte_i == 8'h00) begin
                  st_o.phase = PH_FINAL_OK;
                  res_o = mk_res(1'b1, IDLE_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
                end else begin
                  st_o.retry_count = retry_dec;
                  if (retry_dec == '0) begin
                    st_o.phase = PH_FINAL_TO;
                    res_o = mk_res(1'b1, IDLE_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
                  end else begin
                    st_o.phase      = PH_C55_SEND;
                    st_o.byte_count = '0;
                    res_o = mk_res(1'b1, OP_CMD55, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                  end
                end
              end
              default: begin
                if (rx_byte_i != 8'h00) begin
                  st_o.phase = PH_IDLE;
                  res_o = mk_res(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, ST_CMD_REJECTED);
                end else if (st_i.operation == CMD_READ) begin
                  st_o.phase      = PH_TOKEN;
                  st_o.wait_count = '0;
                  st_o.byte_count = '0;
                  res_o = mk_res(1'b1, IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                end else begin
                  st_o.phase = PH_WTOKEN;
                  res_o = mk_res(1'b1, TOKEN_START, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                end
              end
            endcase
          end
        end
        PH_TOKEN: begin
          st_o.wait_count = wc_inc;
          if (rx_byte_i == TOKEN_START) begin
            st_o.phase      = PH_RDATA;
            st_o.wait_count = '0;
            st_o.byte_count = '0;
            res_o = mk_res(1'b1, IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
          end else if (wc_inc >= token_lim) begin
            st_o.phase = PH_IDLE;
            res_o = mk_res(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, ST_TOKEN_TIMEOUT);
          end else begin
            res_o = mk_res(1'b1, IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
          end
        end
        PH_RDATA: begin
          st_o.byte_count = bc_inc;
          if (bc_inc >= COUNT_W'(BLOCK_BYTES)) begin
            st_o.phase      = PH_RCRC;
            st_o.byte_count = '0;
          end
          res_o = mk_res(1'b1, IDLE_BYTE, 1'b1, 1'b1, rx_byte_i, 1'b0, ST_OK);
        end
        PH_RCRC: begin
          st_o.byte_count = bc_inc;
          if (bc_inc < COUNT_W'(2)) begin
            res_o = mk_res(1'b1, IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
          end else begin
            st_o.phase = PH_FINAL_OK;
            res_o = mk_res(1'b1, IDLE_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
          end
        end
        PH_WTOKEN: begin
          st_o.phase      = PH_WDATA;
          st_o.byte_count = '0;
          res_o = mk_res(1'b1, write_byte_i, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
        end
        PH_WDATA: begin
          st_o.byte_count = bc_inc;
          if (bc_inc < COUNT_W'(BLOCK_BYTES)) begin
            res_o = mk_res(1'b1, write_byte_i, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
          end else begin
            st_o.phase      = PH_WCRC;
            st_o.byte_count = '0;
            res_o = mk_res(1'b1, IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
          end
        end
        PH_WCRC: begin
          st_o.byte_count = bc_inc;
          if (bc_inc >= COUNT_W'(2)) begin
            st_o.phase = PH_DRESP;
          end
          res_o = mk_res(1'b1, IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
        end
        PH_DRESP: begin
          if ((rx_byte_i & DRESP_MASK) != DRESP_OK) begin
            st_o.phase = PH_IDLE;
            res_o = mk_res(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, ST_DATA_REJECTED);
          end else begin
            st_o.phase = PH_BUSY;
            res_o = mk_res(1'b1, IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
          end
        end
        PH_BUSY: begin
          if (rx_byte_i == 8'h00) begin
            res_o = mk_res(1'b1, IDLE_BYTE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
          end else begin
            st_o.phase = PH_FINAL_OK;
            res_o = mk_res(1'b1, IDLE_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
          end
        end
        PH_FINAL_OK: begin
          st_o.phase = PH_IDLE;
          res_o = mk_res(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, ST_OK);
        end
        PH_FINAL_TO: begin
          st_o.phase = PH_IDLE;
          res_o = mk_res(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, ST_INIT_TIMEOUT);
        end
        default: begin
          st_o.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule
